// ===== hw/rtl/dd_pkg.sv =====
package dd_pkg;

	// default configuration
	localparam int MAX_SCALE_DEF = 28;
	localparam int MANT_BITS_DEF = 96;

	// fixed field widths
	localparam int LOW_W   = 64;
	localparam int HIGH_W  = 32;
	localparam int MANT_W  = LOW_W + HIGH_W;
	localparam int SCALE_W = 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_R10,
		ST_DSTEP,
		ST_Q10,
		ST_QADD,
		ST_ROUND,
		ST_INC,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_LARGE = 2'd1,
		STAT_SMALL = 2'd2,
		STAT_DIV0  = 2'd3
	} status_t;

	typedef struct packed {
		logic [MANT_W-1:0]  mant;
		logic [SCALE_W-1:0] scale;
		logic               neg;
		status_t            status;
	} result_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_ctl_t;

endpackage

// ===== hw/rtl/decimal96_divider_top.sv =====
// Decimal divider: mantissa (96 bits), scale 0..28 and sign per operand; the
// quotient comes back in the same format with status ok, too large, too small
// or divide by zero. All mantissa arithmetic runs on one shared add/subtract
// unit under a small sequencer, one item at a time. An item runs the binary
// integer division, then brings down decimal digits (up to 2*MAX_SCALE of
// them), then the last check and rounding, and hands off; a divide by zero
// skips straight to the hand-off. in_ready is high while the sequencer is
// idle; a finished result waits in an output register.
module decimal96_divider_top import dd_pkg::*; #(
	parameter int MAX_SCALE = MAX_SCALE_DEF,
	parameter int MANTISSA_BITS = MANT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [LOW_W-1:0]   dividend_low,
	input  logic [HIGH_W-1:0]  dividend_high,
	input  logic [SCALE_W-1:0] dividend_scale,
	input  logic               dividend_negative,
	input  logic [LOW_W-1:0]   divisor_low,
	input  logic [HIGH_W-1:0]  divisor_high,
	input  logic [SCALE_W-1:0] divisor_scale,
	input  logic               divisor_negative,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [LOW_W-1:0]   quotient_low,
	output logic [HIGH_W-1:0]  quotient_high,
	output logic [SCALE_W-1:0] quotient_scale,
	output logic               quotient_negative,
	output logic [1:0]         status
);

	core_ctl_t ctl;
	result_t   res, out_q;
	logic      out_valid_q, take;

	// load the output register when it is empty or being drained
	assign take     = !out_valid_q || out_ready;
	assign in_ready = ctl.idle;

	dd_core #(.MAX_SCALE(MAX_SCALE), .MANT_BITS(MANTISSA_BITS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid),
		.take   (take),
		.a_in   ({dividend_high, dividend_low}),
		.sa_in  (dividend_scale),
		.na_in  (dividend_negative),
		.b_in   ({divisor_high, divisor_low}),
		.sb_in  (divisor_scale),
		.nb_in  (divisor_negative),
		.ctl    (ctl),
		.res    (res)
	);

	// hold the result until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.done && take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.done && take) out_q <= res;
	end

	assign out_valid         = out_valid_q;
	assign quotient_low      = out_q.mant[LOW_W-1:0];
	assign quotient_high     = out_q.mant[MANT_W-1:LOW_W];
	assign quotient_scale    = out_q.scale;
	assign quotient_negative = out_q.neg;
	assign status            = out_q.status;

endmodule

// ===== hw/rtl/dd_addsub.sv =====
module dd_addsub import dd_pkg::*; #(
	parameter int W = MANT_BITS_DEF + 5
) (
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	input  logic         sub,
	output logic [W-1:0] res
);

	// add, or subtract by adding the complement with a carry in
	assign res = x + (sub ? ~y : y) + W'(sub);

endmodule

// ===== hw/rtl/dd_core.sv =====
module dd_core import dd_pkg::*; #(
	parameter int MAX_SCALE = MAX_SCALE_DEF,
	parameter int MANT_BITS = MANT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               take,
	input  logic [MANT_W-1:0]  a_in,
	input  logic [SCALE_W-1:0] sa_in,
	input  logic               na_in,
	input  logic [MANT_W-1:0]  b_in,
	input  logic [SCALE_W-1:0] sb_in,
	input  logic               nb_in,
	output core_ctl_t          ctl,
	output result_t            res
);

	localparam int N     = MANT_BITS;
	localparam int W     = N + 5;
	localparam int CNT_W = $clog2(N);
	localparam logic signed [SCALE_W:0] MAXS = (SCALE_W+1)'(MAX_SCALE);
	localparam logic signed [SCALE_W:0] ONES = (SCALE_W+1)'(1);

	state_t state_q, state_d;

	logic [N-1:0]               a_q, b_q, r_q, q_q;
	logic [N+3:0]               rw_q, t_q;
	logic [3:0]                 dq_q;
	logic [1:0]                 k_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [SCALE_W:0]    scale_q;
	logic                       neg_q;
	status_t                    status_q;

	logic [W-1:0] ax, ay, ares;
	logic         asub, borrow, fit;
	logic [N:0]   rem2;
	logic [N-1:0] a_m, b_m;
	logic [SCALE_W-1:0] sa_c, sb_c;

	// mask and clamp the operands
	assign a_m  = a_in[N-1:0];
	assign b_m  = b_in[N-1:0];
	assign sa_c = (sa_in > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : sa_in;
	assign sb_c = (sb_in > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : sb_in;

	assign rem2   = {r_q, a_q[N-1]};
	assign borrow = ares[W-1];
	assign fit    = (ares[W-1:N] == '0);

	dd_addsub #(.W(W)) u_addsub (
		.x   (ax),
		.y   (ay),
		.sub (asub),
		.res (ares)
	);

	// select the shared adder operands
	always_comb begin
		ax   = '0;
		ay   = '0;
		asub = 1'b0;
		unique case (state_q)
			ST_DIV: begin
				ax   = W'(rem2);
				ay   = W'(b_q);
				asub = 1'b1;
			end
			ST_R10: begin
				ax = W'({r_q, 3'b000});
				ay = W'({r_q, 1'b0});
			end
			ST_DSTEP: begin
				ax   = W'(rw_q);
				ay   = W'({b_q, 3'b000}) >> (2'd3 - k_q);
				asub = 1'b1;
			end
			ST_Q10: begin
				ax = W'({q_q, 3'b000});
				ay = W'({q_q, 1'b0});
			end
			ST_QADD: begin
				ax = W'(t_q);
				ay = W'(dq_q);
			end
			ST_ROUND: begin
				ax   = W'(b_q);
				ay   = W'({r_q, 1'b0});
				asub = 1'b1;
			end
			ST_INC: begin
				ax = W'(q_q);
				ay = W'(1'b1);
			end
			default: begin
			end
		endcase
	end

	// sequence the steps
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = (b_m == '0) ? ST_DONE : ST_DIV;
			ST_DIV:   if (cnt_q == CNT_W'(N-1)) state_d = ST_CHECK;
			ST_CHECK: begin
				if (scale_q < 0 || (r_q != '0 && scale_q < MAXS)) state_d = ST_R10;
				else state_d = ST_ROUND;
			end
			ST_R10:   state_d = ST_DSTEP;
			ST_DSTEP: if (k_q == 2'd0) state_d = ST_Q10;
			ST_Q10:   state_d = ST_QADD;
			ST_QADD: begin
				if (fit) state_d = ST_CHECK;
				else if (scale_q < 0) state_d = ST_DONE;
				else state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (r_q != '0 && (borrow || (ares == '0 && q_q[0]))) state_d = ST_INC;
				else state_d = ST_DONE;
			end
			ST_INC:   state_d = ST_DONE;
			ST_DONE:  if (take) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (start) begin
				a_q      <= a_m;
				b_q      <= b_m;
				r_q      <= '0;
				q_q      <= '0;
				cnt_q    <= '0;
				scale_q  <= $signed({1'b0, sa_c}) - $signed({1'b0, sb_c});
				neg_q    <= na_in ^ nb_in;
				status_q <= (b_m == '0) ? STAT_DIV0 : STAT_OK;
			end
			ST_DIV: begin
				a_q   <= a_q << 1;
				r_q   <= borrow ? rem2[N-1:0] : ares[N-1:0];
				q_q   <= {q_q[N-2:0], ~borrow};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_R10: begin
				rw_q <= ares[N+3:0];
				dq_q <= '0;
				k_q  <= 2'd3;
			end
			ST_DSTEP: begin
				if (!borrow) rw_q <= ares[N+3:0];
				dq_q <= {dq_q[2:0], ~borrow};
				k_q  <= k_q - 2'd1;
			end
			ST_Q10: t_q <= ares[N+3:0];
			ST_QADD: begin
				if (fit) begin
					q_q     <= ares[N-1:0];
					r_q     <= rw_q[N-1:0];
					scale_q <= scale_q + ONES;
				end else if (scale_q < 0) begin
					status_q <= neg_q ? STAT_SMALL : STAT_LARGE;
				end
			end
			ST_INC: begin
				q_q <= ares[N-1:0];
				if (!fit) status_q <= neg_q ? STAT_SMALL : STAT_LARGE;
			end
			default: begin
			end
		endcase
	end

	// drive status and result
	always_comb begin
		ctl.idle   = (state_q == ST_IDLE);
		ctl.done   = (state_q == ST_DONE);
		res.neg    = neg_q;
		res.status = status_q;
		if (status_q == STAT_OK) begin
			res.mant  = MANT_W'(q_q);
			res.scale = scale_q[SCALE_W-1:0];
		end else begin
			res.mant  = '0;
			res.scale = '0;
		end
	end

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= CNT_W'(N-1)))
		else $error("division step count out of range");

	a_scale_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (scale_q <= MAXS))
		else $error("scale above maximum");

	a_digit_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DSTEP && k_q == 2'd0) |=> (state_q == ST_Q10))
		else $error("digit step did not end after four passes");

endmodule

// ===== dv/tb_decimal96_divider_top.sv =====
module tb_decimal96_divider_top;
	import dd_pkg::*;

	typedef struct {
		logic [LOW_W-1:0]   a_low;
		logic [HIGH_W-1:0]  a_high;
		logic [SCALE_W-1:0] a_scale;
		logic               a_neg;
		logic [LOW_W-1:0]   b_low;
		logic [HIGH_W-1:0]  b_high;
		logic [SCALE_W-1:0] b_scale;
		logic               b_neg;
		bit                 drain_first;
	} div_item_t;

	typedef struct {
		logic [LOW_W-1:0]   q_low;
		logic [HIGH_W-1:0]  q_high;
		logic [SCALE_W-1:0] q_scale;
		logic               q_neg;
		status_t            q_status;
	} quotient_t;

	localparam logic [127:0] MANT_LIMIT = 128'd1 << MANT_W;
	localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [LOW_W-1:0]   dividend_low;
	logic [HIGH_W-1:0]  dividend_high;
	logic [SCALE_W-1:0] dividend_scale;
	logic               dividend_negative;
	logic [LOW_W-1:0]   divisor_low;
	logic [HIGH_W-1:0]  divisor_high;
	logic [SCALE_W-1:0] divisor_scale;
	logic               divisor_negative;
	logic out_valid;
	logic out_ready;
	logic [LOW_W-1:0]   quotient_low;
	logic [HIGH_W-1:0]  quotient_high;
	logic [SCALE_W-1:0] quotient_scale;
	logic               quotient_negative;
	logic [1:0]         status;

	div_item_t pending_divs[$];
	quotient_t expected_quotients[$];
	div_item_t cur_div;
	int mismatch_count = 0;
	int cycle_count = 0;
	bit stimulus_done = 0;

	decimal96_divider_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.dividend_low(dividend_low), .dividend_high(dividend_high),
		.dividend_scale(dividend_scale), .dividend_negative(dividend_negative),
		.divisor_low(divisor_low), .divisor_high(divisor_high),
		.divisor_scale(divisor_scale), .divisor_negative(divisor_negative),
		.out_valid(out_valid), .out_ready(out_ready),
		.quotient_low(quotient_low), .quotient_high(quotient_high),
		.quotient_scale(quotient_scale), .quotient_negative(quotient_negative),
		.status(status)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// compute the expected decimal quotient of one operand pair
	function automatic quotient_t divide_decimal(div_item_t it);
		logic [127:0] num, den, quo, rem, nquo, digit, twice;
		int sa, sb, scale;
		status_t st;
		quotient_t res;
		bit up;
		num = {32'd0, it.a_high, it.a_low};
		den = {32'd0, it.b_high, it.b_low};
		sa = (it.a_scale > MAX_SCALE_DEF) ? MAX_SCALE_DEF : it.a_scale;
		sb = (it.b_scale > MAX_SCALE_DEF) ? MAX_SCALE_DEF : it.b_scale;
		res.q_low = '0;
		res.q_high = '0;
		res.q_scale = '0;
		res.q_neg = it.a_neg ^ it.b_neg;
		st = STAT_OK;
		if (den == 0) begin
			res.q_status = STAT_DIV0;
			return res;
		end
		quo = num / den;
		rem = num % den;
		scale = sa - sb;
		// bring down digits until the scale is no longer negative
		while (scale < 0 && st == STAT_OK) begin
			digit = (rem * 10) / den;
			rem = (rem * 10) % den;
			nquo = quo * 10 + digit;
			if (nquo >= MANT_LIMIT)
				st = res.q_neg ? STAT_SMALL : STAT_LARGE;
			quo = nquo;
			scale++;
		end
		// refine while a remainder is left and the digit still fits
		while (st == STAT_OK && rem != 0 && scale < MAX_SCALE_DEF) begin
			digit = (rem * 10) / den;
			nquo = quo * 10 + digit;
			if (nquo >= MANT_LIMIT)
				break;
			rem = (rem * 10) % den;
			quo = nquo;
			scale++;
		end
		// round half to even
		if (st == STAT_OK && rem != 0) begin
			twice = rem << 1;
			up = (twice > den) || (twice == den && quo[0]);
			if (up) begin
				quo = quo + 1;
				if (quo >= MANT_LIMIT)
					st = res.q_neg ? STAT_SMALL : STAT_LARGE;
			end
		end
		if (st == STAT_OK) begin
			res.q_low = quo[63:0];
			res.q_high = quo[95:64];
			res.q_scale = scale[SCALE_W-1:0];
		end
		res.q_status = st;
		return res;
	endfunction

	function automatic logic [MANT_W-1:0] rand_mantissa();
		logic [MANT_W-1:0] m;
		m = {$urandom, $urandom, $urandom};
		return m >> $urandom_range(0, MANT_W - 1);
	endfunction

	task automatic queue_div(logic [MANT_W-1:0] a, int sa, bit na,
			logic [MANT_W-1:0] b, int sb, bit nb, bit drain);
		div_item_t it;
		it.a_low = a[63:0];
		it.a_high = a[95:64];
		it.a_scale = SCALE_W'(sa);
		it.a_neg = na;
		it.b_low = b[63:0];
		it.b_high = b[95:64];
		it.b_scale = SCALE_W'(sb);
		it.b_neg = nb;
		it.drain_first = drain;
		pending_divs.push_back(it);
	endtask

	function automatic bit quiet_window();
		return cycle_count > 200000 && cycle_count < 260000;
	endfunction

	// drive operand transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			dividend_low <= '0;
			dividend_high <= '0;
			dividend_scale <= '0;
			dividend_negative <= 1'b0;
			divisor_low <= '0;
			divisor_high <= '0;
			divisor_scale <= '0;
			divisor_negative <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_quotients.push_back(divide_decimal(cur_div));
			if (!in_valid || in_ready) begin
				if (pending_divs.size() > 0
						&& !(pending_divs[0].drain_first
						&& (expected_quotients.size() > 0 || (in_valid && in_ready)))
						&& (quiet_window() || $urandom_range(0, 99) >= 23)) begin
					cur_div = pending_divs.pop_front();
					in_valid <= 1'b1;
					dividend_low <= cur_div.a_low;
					dividend_high <= cur_div.a_high;
					dividend_scale <= cur_div.a_scale;
					dividend_negative <= cur_div.a_neg;
					divisor_low <= cur_div.b_low;
					divisor_high <= cur_div.b_high;
					divisor_scale <= cur_div.b_scale;
					divisor_negative <= cur_div.b_neg;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// accept and check quotient transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (out_valid && out_ready) begin
				if (expected_quotients.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected quotient transfer: %h %h %0d %b %0d",
							quotient_high, quotient_low, quotient_scale,
							quotient_negative, status);
				end else begin
					quotient_t exp_q;
					exp_q = expected_quotients.pop_front();
					if (quotient_low !== exp_q.q_low || quotient_high !== exp_q.q_high
							|| quotient_scale !== exp_q.q_scale
							|| quotient_negative !== exp_q.q_neg
							|| status !== exp_q.q_status) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: exp %h_%h s%0d n%b st%0d, got %h_%h s%0d n%b st%0d",
								exp_q.q_high, exp_q.q_low, exp_q.q_scale, exp_q.q_neg,
								exp_q.q_status, quotient_high, quotient_low,
								quotient_scale, quotient_negative, status);
					end
				end
			end
			out_ready <= quiet_window() || $urandom_range(0, 99) >= 23;
		end
	end

	initial begin
		logic [MANT_W-1:0] a, b;
		arst_n = 1'b0;
		// corner cases: extremes, zeros, overflow both signs
		queue_div(MANT_MAX, 0, 0, MANT_MAX, 0, 0, 0);
		queue_div(MANT_MAX, 28, 1, 1, 0, 0, 0);
		queue_div(MANT_MAX, 0, 0, 1, 28, 0, 0);
		queue_div(MANT_MAX, 0, 1, 1, 28, 0, 0);
		queue_div(MANT_MAX, 0, 1, 1, 28, 1, 0);
		queue_div(12345, 3, 0, 0, 0, 0, 0);
		queue_div(0, 0, 1, 0, 28, 0, 0);
		queue_div(0, 5, 1, 7, 20, 0, 0);
		queue_div(0, 28, 0, MANT_MAX, 0, 1, 0);
		queue_div(1, 0, 0, 3, 0, 0, 0);
		queue_div(2, 0, 1, 3, 0, 0, 0);
		queue_div(1, 0, 0, 8, 0, 0, 0);
		queue_div(MANT_MAX, 0, 0, MANT_MAX - 1, 0, 1, 0);
		queue_div(MANT_MAX, 0, 0, 3, 0, 0, 0);
		queue_div(MANT_MAX, 0, 0, 2, 1, 0, 0);
		queue_div(5, 28, 0, 10, 28, 0, 0);
		queue_div(1, 28, 0, MANT_MAX, 0, 0, 0);
		queue_div(MANT_MAX, 14, 1, 7, 3, 1, 0);
		queue_div(25, 1, 0, 2, 0, 0, 0);
		queue_div(15, 1, 0, 2, 0, 0, 0);
		// scales above the maximum are clamped
		queue_div(12345, 31, 0, 7, 0, 1, 0);
		queue_div(12345, 0, 0, 7, 30, 0, 0);
		for (int i = 0; i < 1750; i++) begin
			a = rand_mantissa();
			b = ($urandom_range(0, 39) == 0) ? '0 : rand_mantissa();
			if ($urandom_range(0, 19) == 0)
				a = '0;
			queue_div(a, $urandom_range(0, 28), $urandom_range(0, 1),
				b, $urandom_range(0, 28), $urandom_range(0, 1), i == 300 || i == 1200);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_divs.size() == 0);
		@(posedge clk);
		while (in_valid)
			@(posedge clk);
		while (expected_quotients.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		if (mismatch_count == 0 && expected_quotients.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#100000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
